// ----- hw/rtl/dtcs_pkg.sv -----
// types and constants shared by the delete-to command sequencer
// no dependencies

package dtcs_pkg;

  localparam int OBJ_W   = 48;
  localparam int CNT_W   = 6;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd50;
  localparam logic             REG_START_POINT = 1'b0;

  typedef enum logic [1:0] {
    MODE_RAISE = 2'd0,
    MODE_DONE  = 2'd1,
    MODE_FAIL  = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_DELETE = 3'd0,
    CMD_EMPTY  = 3'd1,
    CMD_MARKER = 3'd2,
    CMD_ERROR  = 3'd3,
    CMD_NONE   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic             push;
    logic             flush;
    cmd_t             cmd;
    logic [OBJ_W-1:0] obj;
  } dtcs_emit_t;

  typedef struct packed {
    logic can_push;
    logic can_flush;
  } dtcs_ostat_t;

endpackage

// ----- hw/rtl/dtcs_out_stage.sv -----
// result staging for the delete-to command sequencer: one lookahead entry
// that decides the last flag, and the output register; depends on dtcs_pkg

module dtcs_out_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  dtcs_pkg::dtcs_emit_t      em,
  output dtcs_pkg::dtcs_ostat_t     st,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [2:0]                command,
  output logic [dtcs_pkg::OBJ_W-1:0] object_number,
  output logic                      last
);
  import dtcs_pkg::*;

  logic             held_v;
  cmd_t             held_cmd;
  logic [OBJ_W-1:0] held_obj;
  logic             out_free;

  assign out_free     = !result_valid || !result_stall;
  assign st.can_push  = !held_v || out_free;
  assign st.can_flush = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      held_v       <= 1'b0;
    end else begin
      if (em.flush && out_free) begin
        result_valid  <= 1'b1;
        command       <= held_v ? held_cmd : CMD_NONE;
        object_number <= held_v ? held_obj : '0;
        last          <= 1'b1;
        held_v        <= 1'b0;
      end else if (em.push) begin
        if (held_v) begin
          result_valid  <= 1'b1;
          command       <= held_cmd;
          object_number <= held_obj;
          last          <= 1'b0;
        end else if (out_free) begin
          result_valid <= 1'b0;
        end
        held_v   <= 1'b1;
        held_cmd <= em.cmd;
        held_obj <= em.obj;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/delete_to_command_sequencer_core.sv -----
// top level of the delete-to command sequencer: register port, sequencer
// with a bit-serial carry scan; depends on dtcs_pkg and dtcs_out_stage
//
// usage:
//   input channel (item_valid / item_stall, mode, target) takes one
//   transaction at a time; item_stall stays high until every result of the
//   current transaction has been handed to the output register.
//   output channel (result_valid / result_stall, command, object_number,
//   last) gives one or more results per input transaction, the final one
//   with last set. a transaction that issues nothing gives a single none.
//   each counter step passes through the marker, target, scan and empty
//   states; the carry scan tests one trailing bit of the counter per cycle
//   unless a stalled receiver holds it.
//   results leave through a one-entry lookahead and an output register; a
//   stalled receiver holds the scan once both are full.
//   reset clears target, pending count and flags and loads the counter
//   with 1. writing start_point (offset 0) loads the counter and must be
//   done while idle.

module delete_to_command_sequencer_core #(
  parameter int COUNTER_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtcs_pkg::PADDR_W-1:0]  paddr,
  input  logic [dtcs_pkg::PDATA_W-1:0]  pwdata,
  output logic [dtcs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    mode,
  input  logic [dtcs_pkg::OBJ_W-1:0]    target,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [2:0]                    command,
  output logic [dtcs_pkg::OBJ_W-1:0]    object_number,
  output logic                          last
);
  import dtcs_pkg::*;

  localparam int CB = COUNTER_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MARK  = 6'b000010,
    S_TGT   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_EMPTY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state;
  logic [OBJ_W-1:0]    start_point;
  logic [CB-1:0]       reclaim_target;
  logic [CB-1:0]       progress;
  logic [CNT_W-1:0]    pending_count;
  logic [CNT_W-1:0]    n_out;
  logic                marker_dirty;
  logic                stopping;
  logic                faulted;
  logic [CB-1:0]       obj;
  logic [CB-1:0]       shr;
  logic [CB-1:0]       bmask;

  dtcs_emit_t          em;
  dtcs_ostat_t         ost;

  logic                cfg_wr;
  logic                in_accept;
  logic [63:0]         tgt64;
  logic [CB-1:0]       tgt;
  logic [63:0]         sp64;
  logic [CB-1:0]       cur_dec;
  logic                mark_hit;
  logic                scan_bit;
  logic                scan_hit;
  logic                empty_hit;
  logic                hit;
  logic                room;
  logic                proceed;
  logic                gate_ok;
  cmd_t                emit_cmd;
  logic [CB-1:0]       emit_obj;
  logic [63:0]         emit_obj64;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_START_POINT);
  assign prdata = (paddr[3] == REG_START_POINT) ?
                  {{(PDATA_W-OBJ_W){1'b0}}, start_point} : '0;

  assign tgt64 = {{(64-OBJ_W){1'b0}}, target};
  assign tgt   = tgt64[CB-1:0];
  assign sp64  = {{(64-OBJ_W){1'b0}}, pwdata[OBJ_W-1:0]};

  assign item_stall = (state != S_IDLE);
  assign in_accept  = item_valid && (state == S_IDLE);

  // emit decision for the current step
  assign gate_ok   = !stopping && !faulted && (pending_count == '0);
  assign cur_dec   = progress - {{(CB-1){1'b0}}, 1'b1};
  assign mark_hit  = (progress[7:0] == 8'd0) && marker_dirty;
  assign scan_bit  = shr[0] && (bmask != '0);
  assign scan_hit  = scan_bit && (obj != bmask);
  assign empty_hit = ((progress & cur_dec) == '0) || (progress[7:0] == 8'd0);

  always_comb begin
    hit      = 1'b0;
    emit_obj = progress;
    emit_cmd = CMD_NONE;
    unique case (state)
      S_MARK: begin
        hit      = gate_ok && mark_hit;
        emit_cmd = CMD_MARKER;
      end
      S_SCAN: begin
        hit      = scan_hit;
        emit_cmd = CMD_DELETE;
        emit_obj = obj;
      end
      S_EMPTY: begin
        hit      = empty_hit;
        emit_cmd = CMD_EMPTY;
      end
      S_IDLE: begin
        hit      = in_accept && (mode_t'(mode) == MODE_FAIL);
        emit_cmd = CMD_ERROR;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // the error result is always the only one of its transaction
  assign emit_obj64 = {{(64-CB){1'b0}}, emit_obj};
  assign room       = (state == S_IDLE) || (n_out < MAX_RESULTS);
  assign em.cmd     = emit_cmd;
  assign em.push    = hit && room && ost.can_push;
  assign em.obj     = (em.cmd == CMD_ERROR) ? '0 : emit_obj64[OBJ_W-1:0];
  assign em.flush   = (state == S_DONE);
  assign proceed    = !hit || !room || ost.can_push;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      start_point    <= {{(OBJ_W-1){1'b0}}, 1'b1};
      reclaim_target <= '0;
      progress       <= {{(CB-1){1'b0}}, 1'b1};
      pending_count  <= '0;
      n_out          <= '0;
      marker_dirty   <= 1'b0;
      stopping       <= 1'b0;
      faulted        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_point  <= pwdata[OBJ_W-1:0];
        progress     <= sp64[CB-1:0];
        marker_dirty <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            n_out <= '0;
            unique case (mode_t'(mode))
              MODE_RAISE: begin
                if (tgt > reclaim_target) begin
                  reclaim_target <= tgt;
                end
                state <= S_MARK;
              end
              MODE_DONE: begin
                if (pending_count != '0) begin
                  pending_count <= pending_count - 6'd1;
                end
                state <= (pending_count == 6'd1) ? S_MARK : S_DONE;
              end
              MODE_FAIL: begin
                if (pending_count != '0) begin
                  pending_count <= pending_count - 6'd1;
                end
                faulted <= 1'b1;
                state   <= S_DONE;
              end
              MODE_STOP: begin
                stopping <= 1'b1;
                state    <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MARK: begin
          if (!gate_ok) begin
            state <= S_DONE;
          end else if (proceed) begin
            if (mark_hit) begin
              marker_dirty <= 1'b0;
            end
            state <= S_TGT;
          end
        end
        S_TGT: begin
          obj   <= progress;
          shr   <= progress;
          bmask <= {{(CB-1){1'b0}}, 1'b1};
          state <= (reclaim_target <= progress) ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          if (!scan_bit) begin
            state <= S_EMPTY;
          end else if (proceed) begin
            obj   <= obj & ~bmask;
            shr   <= shr >> 1;
            bmask <= bmask << 1;
          end
        end
        S_EMPTY: begin
          if (proceed) begin
            progress     <= progress + {{(CB-1){1'b0}}, 1'b1};
            marker_dirty <= 1'b1;
            state        <= ((pending_count != '0) || em.push) ? S_DONE : S_MARK;
          end
        end
        S_DONE: begin
          if (ost.can_flush) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (em.push && (state != S_IDLE)) begin
        pending_count <= pending_count + 6'd1;
      end
      if (em.push && (state != S_IDLE)) begin
        n_out <= n_out + 6'd1;
      end
    end
  end

  dtcs_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .em            (em),
    .st            (ost),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .command       (command),
    .object_number (object_number),
    .last          (last)
  );

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= MAX_RESULTS)
    else $error("pending count beyond result limit");

  a_scan_gated: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (!stopping && !faulted && reclaim_target > progress))
    else $error("scan running while blocked or at target");

  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && ost.can_flush) |=> (result_valid && last))
    else $error("finish without a last result");

  a_no_push_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !em.push)
    else $error("result pushed during finish");

endmodule

// ----- dv/dtcs_tb_pkg.sv -----
// scoreboard for the delete-to command sequencer testbench: predicts the commands
// that each input transaction causes and checks the result stream against them
// depends on dtcs_pkg
package dtcs_tb_pkg;
  import dtcs_pkg::*;

  typedef struct packed {
    cmd_t             cmd;
    logic [OBJ_W-1:0] obj;
    logic             last;
  } cmd_rec_t;

  class reclaim_scoreboard;
    logic [OBJ_W-1:0] start_point;
    logic [OBJ_W-1:0] reclaim_target;
    logic [OBJ_W-1:0] progress;
    logic [CNT_W-1:0] outstanding;
    bit               marker_dirty;
    bit               stopping;
    bit               faulted;
    cmd_rec_t         burst[$];
    cmd_rec_t         expected_cmds[$];
    int               transactions;
    int               results;
    int               mismatches;
    int               deletes;
    int               markers;
    int               longest_burst;

    function new();
      start_point    = 1;
      reclaim_target = '0;
      progress       = 1;
      outstanding    = '0;
      marker_dirty   = 1'b0;
      stopping       = 1'b0;
      faulted        = 1'b0;
      transactions   = 0;
      results        = 0;
      mismatches     = 0;
      deletes        = 0;
      markers        = 0;
      longest_burst  = 0;
    endfunction

    function void load_start(logic [OBJ_W-1:0] v);
      start_point  = v;
      progress     = v;
      marker_dirty = 1'b0;
    endfunction

    // commands past the result limit are dropped
    function bit emit(cmd_t c, logic [OBJ_W-1:0] o);
      cmd_rec_t rec;
      if (burst.size() >= int'(MAX_RESULTS)) return 1'b0;
      rec.cmd  = c;
      rec.obj  = o;
      rec.last = 1'b0;
      burst.push_back(rec);
      if (c == CMD_DELETE) deletes++;
      if (c == CMD_MARKER) markers++;
      return 1'b1;
    endfunction

    function void issue(cmd_t c, logic [OBJ_W-1:0] o);
      if (emit(c, o)) outstanding = outstanding + 1'b1;
    endfunction

    // walk the counter toward the target while nothing is outstanding
    function void step_counter();
      logic [OBJ_W-1:0] cur;
      logic [OBJ_W-1:0] nxt;
      logic [OBJ_W-1:0] bitv;
      logic [OBJ_W-1:0] obj;
      while (!stopping && !faulted && outstanding == 0) begin
        cur = progress;
        nxt = cur + 1'b1;
        if (cur[7:0] == 8'd0 && marker_dirty) begin
          issue(CMD_MARKER, cur);
          marker_dirty = 1'b0;
        end
        if (reclaim_target <= cur) break;
        for (int b = 0; b < OBJ_W; b++) begin
          if (cur[b] && !nxt[b]) begin
            bitv = {{(OBJ_W-1){1'b0}}, 1'b1} << b;
            obj  = cur & ~(bitv - 1'b1);
            if (obj != bitv) issue(CMD_DELETE, obj);
          end
        end
        if ((cur & (cur - 1'b1)) == '0 || cur[7:0] == 8'd0) issue(CMD_EMPTY, cur);
        progress     = nxt;
        marker_dirty = 1'b1;
        if (outstanding != 0) break;
      end
    endfunction

    function void note_item(mode_t m, logic [OBJ_W-1:0] t);
      cmd_rec_t rec;
      burst.delete();
      transactions++;
      case (m)
        MODE_RAISE: begin
          if (t > reclaim_target) reclaim_target = t;
          step_counter();
        end
        MODE_DONE: begin
          if (outstanding != 0) begin
            outstanding = outstanding - 1'b1;
            if (outstanding == 0) step_counter();
          end
        end
        MODE_FAIL: begin
          if (outstanding != 0) outstanding = outstanding - 1'b1;
          faulted = 1'b1;
          void'(emit(CMD_ERROR, '0));
        end
        default: stopping = 1'b1;
      endcase
      if (burst.size() == 0) void'(emit(CMD_NONE, '0));
      rec = burst.pop_back();
      rec.last = 1'b1;
      burst.push_back(rec);
      if (burst.size() > longest_burst) longest_burst = burst.size();
      foreach (burst[i]) expected_cmds.push_back(burst[i]);
    endfunction

    function void check_result(logic [2:0] c, logic [OBJ_W-1:0] o, logic l);
      cmd_rec_t e;
      results++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: command %0d object %h last %0b", c, o, l);
        return;
      end
      e = expected_cmds.pop_front();
      if (c !== e.cmd || o !== e.obj || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected %0d %h %0b, got %0d %h %0b",
                   results, e.cmd, e.obj, e.last, c, o, l);
      end
    endfunction
  endclass

endpackage

// ----- dv/tb.sv -----
// top of the delete-to command sequencer testbench: clock, reset, register writes,
// transaction driver, result monitor and stimulus phases
// depends on dtcs_pkg, dtcs_tb_pkg and delete_to_command_sequencer_core
module tb;
  import dtcs_pkg::*;
  import dtcs_tb_pkg::*;

  localparam logic [PADDR_W-1:0] START_POINT_ADDR = PADDR_W'(8 * int'(REG_START_POINT));
  localparam logic [OBJ_W-1:0]   OBJ_MAX          = '1;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [PDATA_W-1:0]   pwdata        = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 item_valid    = 1'b0;
  logic                 item_stall;
  logic [1:0]           mode          = '0;
  logic [OBJ_W-1:0]     target        = '0;
  logic                 result_valid;
  logic                 result_stall  = 1'b0;
  logic [2:0]           command;
  logic [OBJ_W-1:0]     object_number;
  logic                 last;
  bit                   quiet         = 1'b0;
  reclaim_scoreboard    sb;

  delete_to_command_sequencer_core u_top (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(command, object_number, last);
  end

  // receiver stall bursts, none once the run goes quiet
  initial begin
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [OBJ_W-1:0] rand_obj();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[OBJ_W-1:0];
  endfunction

  // valid stays high after acceptance until the next transaction or a gap
  task automatic send_item(input mode_t m, input logic [OBJ_W-1:0] t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode       <= m;
    target     <= t;
    do @(posedge clk); while (item_stall);
    sb.note_item(m, t);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_start_point(input logic [OBJ_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_POINT_ADDR;
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.load_start(v);
  endtask

  // mostly raise-then-complete sequences, with stray completions and low targets
  task automatic run_phase(input logic [OBJ_W-1:0] start, input int count);
    int pick;
    drain_results();
    write_start_point(start);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (sb.outstanding != 0) begin
        if (pick < 85) send_item(MODE_DONE, rand_obj());
        else if (pick < 95) send_item(MODE_RAISE, rand_obj() >> $urandom_range(0, 47));
        else send_item(MODE_RAISE, sb.progress + OBJ_W'($urandom_range(1, 40)));
      end else if (pick < 80) begin
        send_item(MODE_RAISE, sb.progress + OBJ_W'($urandom_range(1, 40)));
      end else if (pick < 92) begin
        send_item(MODE_RAISE, rand_obj() >> $urandom_range(0, 47));
      end else begin
        send_item(MODE_DONE, rand_obj());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // stray completion, ignored targets, short runs from the reset start point
    send_item(MODE_DONE, rand_obj());
    send_item(MODE_RAISE, '0);
    send_item(MODE_RAISE, OBJ_W'(3));
    send_item(MODE_RAISE, OBJ_W'(2));
    send_item(MODE_DONE, rand_obj());
    send_item(MODE_DONE, rand_obj());
    drain_results();
    write_start_point('0);
    send_item(MODE_RAISE, OBJ_W'(5));
    repeat (5) send_item(MODE_DONE, rand_obj());
    // carry across the low byte and the first marker
    drain_results();
    write_start_point(OBJ_W'(254));
    send_item(MODE_RAISE, OBJ_W'(258));
    repeat (10) send_item(MODE_DONE, rand_obj());

    run_phase(OBJ_W'(16'hfff0), 40);
    run_phase(OBJ_W'(32'hffff_fff8), 40);
    run_phase((OBJ_W'(1) << (OBJ_W - 1)) - 2'd2, 70);
    run_phase(rand_obj() >> $urandom_range(0, 40), 40);
    quiet = 1'b1;
    run_phase(OBJ_MAX - 9'd259, 30);
    run_phase(OBJ_MAX, 6);

    // stop and failure with commands still outstanding
    drain_results();
    write_start_point(OBJ_MAX - 8'd255);
    send_item(MODE_RAISE, OBJ_MAX);
    while (sb.outstanding < 2) send_item(MODE_DONE, rand_obj());
    send_item(MODE_STOP, rand_obj());
    while (sb.outstanding > 1) send_item(MODE_DONE, rand_obj());
    send_item(MODE_FAIL, rand_obj());
    send_item(MODE_DONE, rand_obj());
    send_item(MODE_RAISE, OBJ_MAX);
    send_item(MODE_FAIL, rand_obj());
    send_item(MODE_STOP, rand_obj());
    repeat (8) send_item(mode_t'($urandom_range(0, 3)), rand_obj());

    drain_results();
    $display("run covered %0d input transactions and %0d results", sb.transactions, sb.results);
    $display("%0d deletes, %0d markers, longest burst %0d, %0d mismatches",
             sb.deletes, sb.markers, sb.longest_burst, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
